// ===== rtl/ecga_pkg.sv =====
// Shared types and codes of the extended center grid averaging block.
// No dependencies.
`default_nettype none
package ecga_pkg;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_NODES_I = 2'd0;
    localparam logic [1:0] REG_NODES_J = 2'd1;
    localparam logic [1:0] REG_NODES_K = 2'd2;

    // Per-node control handed from front to back.
    typedef struct packed {
        logic [7:0]  idx_i;
        logic [7:0]  idx_j;
        logic [15:0] idx_k;
        logic        last_i;
        logic        last_j;
        logic        last_k;
        logic        has_i;
        logic        has_j;
        logic        has_k;
    } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/ecga_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ecga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ecga_front.sv =====
// Front part: accepts nodes, tracks grid position, keeps row and plane history
// and forms the partial sums of each node. Depends on ecga_pkg and ecga_ram.
`default_nettype none
module ecga_front
    import ecga_pkg::*;
#(
    parameter int MAX_I      = 128,
    parameter int MAX_J      = 128,
    parameter int COORD_BITS = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     restart,
    input  wire logic [7:0]                               ni,
    input  wire logic [7:0]                               nj,
    input  wire logic [15:0]                              nk,
    input  wire logic                                     push,
    output logic                                          full,
    input  wire logic [COORD_BITS-1:0]                    node_x,
    input  wire logic [COORD_BITS-1:0]                    node_y,
    input  wire logic [COORD_BITS-1:0]                    node_z,
    output logic                                          q_valid,
    input  wire logic                                     q_ready,
    output ctrl_t                                         q_ctrl,
    output logic [2:0][1:0][3:0][COORD_BITS+1:0]          q_sums
);
    localparam int C   = COORD_BITS;
    localparam int SW  = C + 2;
    localparam int RAW = $clog2(MAX_I);
    localparam int PD  = MAX_I * MAX_J;
    localparam int PAW = $clog2(PD);

    logic [7:0]     cur_i_reg, cur_i_next;
    logic [7:0]     cur_j_reg, cur_j_next;
    logic [15:0]    cur_k_reg, cur_k_next;
    logic [PAW-1:0] pidx_reg, pidx_next;

    logic               b_valid_reg;
    logic [2:0][C-1:0]  b_node_reg;
    ctrl_t              b_ctrl_reg;
    logic [RAW-1:0]     b_raddr_reg;
    logic [PAW-1:0]     b_paddr_reg;
    logic               row_fwd_reg;
    logic [2:0][C-1:0]  row_fwd_data_reg;
    logic               pl_fwd_reg;
    logic [2:0][2*C:0]  pl_fwd_data_reg;

    logic [2:0][C-1:0]  prev_n_reg;
    logic [2:0][C-1:0]  prev_r_reg;
    logic [2:0][C-1:0]  prev_c1_reg;
    logic [2:0][C:0]    prev_c2_reg;

    logic               accept;
    logic               b_fire;
    logic [2:0][C-1:0]  row_q;
    logic [2:0][2*C:0]  pl_q;
    logic [2:0][C-1:0]  row_v;
    logic [2:0][2*C:0]  pl_v;
    logic [2:0][2*C:0]  pl_w;
    logic [RAW-1:0]     rd_raddr;
    logic               wrap_i;
    logic               wrap_j;
    ctrl_t              ctrl_in;

    assign b_fire  = b_valid_reg && q_ready;
    assign full    = b_valid_reg && !q_ready;
    assign accept  = push && !full;
    assign rd_raddr = RAW'(cur_i_reg);
    assign q_valid = b_valid_reg;
    assign q_ctrl  = b_ctrl_reg;

    // Advance raster position.
    always_comb
    begin
        wrap_i     = (cur_i_reg >= ni - 8'd1);
        wrap_j     = (cur_j_reg >= nj - 8'd1);
        cur_i_next = wrap_i ? 8'd0 : cur_i_reg + 8'd1;
        cur_j_next = cur_j_reg;
        cur_k_next = cur_k_reg;
        pidx_next  = pidx_reg + PAW'(1);
        if (wrap_i)
        begin
            cur_j_next = wrap_j ? 8'd0 : cur_j_reg + 8'd1;
            if (wrap_j)
            begin
                pidx_next  = '0;
                cur_k_next = (cur_k_reg >= nk - 16'd1) ? 16'd0 : cur_k_reg + 16'd1;
            end
        end
    end

    always_comb
    begin
        ctrl_in.idx_i  = cur_i_reg;
        ctrl_in.idx_j  = cur_j_reg;
        ctrl_in.idx_k  = cur_k_reg;
        ctrl_in.last_i = (ni > 8'd1) && (cur_i_reg == ni - 8'd1);
        ctrl_in.last_j = (nj > 8'd1) && (cur_j_reg == nj - 8'd1);
        ctrl_in.last_k = (nk > 16'd1) && (cur_k_reg == nk - 16'd1);
        ctrl_in.has_i  = (cur_i_reg != 8'd0);
        ctrl_in.has_j  = (cur_j_reg != 8'd0);
        ctrl_in.has_k  = (cur_k_reg != 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_i_reg   <= '0;
            cur_j_reg   <= '0;
            cur_k_reg   <= '0;
            pidx_reg    <= '0;
            b_valid_reg <= 1'b0;
            row_fwd_reg <= 1'b0;
            pl_fwd_reg  <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                cur_i_reg <= '0;
                cur_j_reg <= '0;
                cur_k_reg <= '0;
                pidx_reg  <= '0;
            end
            else if (accept)
            begin
                cur_i_reg <= cur_i_next;
                cur_j_reg <= cur_j_next;
                cur_k_reg <= cur_k_next;
                pidx_reg  <= pidx_next;
            end
            if (accept)
            begin
                b_valid_reg <= 1'b1;
                row_fwd_reg <= b_fire && (b_raddr_reg == rd_raddr);
                pl_fwd_reg  <= b_fire && (b_paddr_reg == pidx_reg);
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_node_reg       <= {node_z, node_y, node_x};
            b_ctrl_reg       <= ctrl_in;
            b_raddr_reg      <= rd_raddr;
            b_paddr_reg      <= pidx_reg;
            row_fwd_data_reg <= b_node_reg;
            pl_fwd_data_reg  <= pl_w;
        end
        if (b_fire)
        begin
            prev_n_reg <= b_node_reg;
            for (int c = 0; c < 3; c++)
            begin
                prev_r_reg[c]  <= row_v[c];
                prev_c1_reg[c] <= pl_v[c][C-1:0];
                prev_c2_reg[c] <= pl_v[c][2*C:C];
            end
        end
    end

    // Take the word just written when the read hit the same address.
    assign row_v = row_fwd_reg ? row_fwd_data_reg : row_q;
    assign pl_v  = pl_fwd_reg ? pl_fwd_data_reg : pl_q;

    always_comb
    begin
        logic signed [SW-1:0] n, p, r, rp, c1, c1p, c2, c2p;
        for (int c = 0; c < 3; c++)
        begin
            n   = SW'($signed(b_node_reg[c]));
            p   = SW'($signed(prev_n_reg[c]));
            r   = SW'($signed(row_v[c]));
            rp  = SW'($signed(prev_r_reg[c]));
            c1  = SW'($signed(pl_v[c][C-1:0]));
            c1p = SW'($signed(prev_c1_reg[c]));
            c2  = SW'($signed(pl_v[c][2*C:C]));
            c2p = SW'($signed(prev_c2_reg[c]));
            q_sums[c][0][0] = n;
            q_sums[c][0][1] = n + p;
            q_sums[c][0][2] = n + r;
            q_sums[c][0][3] = (n + p) + (r + rp);
            q_sums[c][1][0] = c1;
            q_sums[c][1][1] = c1 + c1p;
            q_sums[c][1][2] = c2;
            q_sums[c][1][3] = c2 + c2p;
            pl_w[c] = {(C+1)'($signed(b_node_reg[c])) + (C+1)'($signed(row_v[c])),
                       b_node_reg[c]};
        end
    end

    ecga_ram #(.WIDTH(3*C), .DEPTH(MAX_I)) u_row_ram (
        .clk   (clk),
        .we    (b_fire),
        .waddr (b_raddr_reg),
        .wdata (b_node_reg),
        .re    (accept),
        .raddr (rd_raddr),
        .rdata (row_q)
    );

    ecga_ram #(.WIDTH(3*(2*C+1)), .DEPTH(PD)) u_plane_ram (
        .clk   (clk),
        .we    (b_fire),
        .waddr (b_paddr_reg),
        .wdata (pl_w),
        .re    (accept),
        .raddr (pidx_reg),
        .rdata (pl_q)
    );
endmodule
`default_nettype wire

// ===== rtl/ecga_queue.sv =====
// Short register queue between front and back.
// No dependencies.
`default_nettype none
module ecga_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_pop,
    output logic      [WIDTH-1:0] out_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push, do_pop;

    assign in_ready  = (count_reg != (AW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_pop && out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ecga_back.sv =====
// Back part: expands each queued node into its extended points, one a cycle
// while the result is popped or empty, into the result register. Depends on ecga_pkg.
`default_nettype none
module ecga_back
    import ecga_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_valid,
    output logic                                      q_pop,
    input  wire ctrl_t                                q_ctrl,
    input  wire logic [2:0][1:0][3:0][COORD_BITS+1:0] q_sums,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [COORD_BITS-1:0]              center_x,
    output logic signed [COORD_BITS-1:0]              center_y,
    output logic signed [COORD_BITS-1:0]              center_z,
    output logic [7:0]                                ext_i,
    output logic [7:0]                                ext_j,
    output logic [15:0]                               ext_k,
    output logic                                      run_last
);
    localparam int C  = COORD_BITS;
    localparam int SW = C + 2;

    logic [2:0]        d_reg, d_next;
    logic              o_valid_reg;
    logic [2:0][C-1:0] o_c_reg, o_c_next;
    logic [7:0]        o_i_reg;
    logic [7:0]        o_j_reg;
    logic [15:0]       o_k_reg;
    logic              o_last_reg;
    logic              adv, fire, last_pt;
    logic              pi, pj, pk;
    logic [1:0]        sel;
    logic [1:0]        sh;

    assign adv   = !o_valid_reg || pop;
    assign fire  = q_valid && adv;
    assign q_pop = fire && last_pt;
    assign empty = !o_valid_reg;

    always_comb
    begin
        last_pt = (d_reg[0] == q_ctrl.last_i) && (d_reg[1] == q_ctrl.last_j)
                  && (d_reg[2] == q_ctrl.last_k);
        pi  = !d_reg[0] && q_ctrl.has_i;
        pj  = !d_reg[1] && q_ctrl.has_j;
        pk  = !d_reg[2] && q_ctrl.has_k;
        sel = {pj, pi};
        sh  = 2'(pi) + 2'(pj) + 2'(pk);
        // Step through points: i offset fastest, then j, then k.
        d_next = '0;
        if (q_ctrl.last_i && !d_reg[0])
        begin
            d_next = {d_reg[2:1], 1'b1};
        end
        else if (q_ctrl.last_j && !d_reg[1])
        begin
            d_next = {d_reg[2], 2'b10};
        end
        else
        begin
            d_next = 3'b100;
        end
    end

    always_comb
    begin
        logic signed [SW:0] tot;
        logic signed [SW:0] shv;
        for (int c = 0; c < 3; c++)
        begin
            tot = (SW+1)'($signed(q_sums[c][0][sel]));
            if (pk)
            begin
                tot = tot + (SW+1)'($signed(q_sums[c][1][sel]));
            end
            shv = tot >>> sh;
            o_c_next[c] = shv[C-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg       <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                o_valid_reg <= q_valid;
            end
            if (fire)
            begin
                d_reg <= last_pt ? 3'b000 : d_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            o_c_reg    <= o_c_next;
            o_i_reg    <= q_ctrl.idx_i + 8'(d_reg[0]);
            o_j_reg    <= q_ctrl.idx_j + 8'(d_reg[1]);
            o_k_reg    <= q_ctrl.idx_k + 16'(d_reg[2]);
            o_last_reg <= last_pt;
        end
    end

    assign center_x = o_c_reg[0];
    assign center_y = o_c_reg[1];
    assign center_z = o_c_reg[2];
    assign ext_i    = o_i_reg;
    assign ext_j    = o_j_reg;
    assign ext_k    = o_k_reg;
    assign run_last = o_last_reg;
endmodule
`default_nettype wire

// ===== rtl/extended_center_grid_average.sv =====
// Top level of the extended center grid averaging block: register port,
// front, queue and back. Depends on ecga_pkg, ecga_front, ecga_queue, ecga_back.
//
// Usage:
//   Program nodes_i, nodes_j, nodes_k over the APB-style port (byte addresses
//   0, 4, 8) while the block is idle; a write to any of them restarts at node
//   (0,0,0). Sizes of zero act as one; nodes_i and nodes_j clamp at MAX_I and
//   MAX_J (255 at most). Push node coordinates (signed Q16.16) in raster
//   order, i fastest, while full is low. Each node yields one extended point,
//   and up to eight when it sits on the last index of several axes; run_last
//   marks its final result. Pop results while empty is low.
// Path: a taken request is registered in the front stage, then moves into
//   the queue, and from the queue it loads the result register.
// Throughput: the back part emits one result per cycle while pop keeps up;
//   interior nodes stream at one per cycle and a four-entry queue absorbs
//   the extra points of boundary nodes.
// Reset: sizes return to one, position to (0,0,0), queue and result empty.
//   History memories need no clearing; only entries written in the current
//   pass are read.
// Stall: while pop is low the result holds; the queue then fills and full rises.
`default_nettype none
module extended_center_grid_average
    import ecga_pkg::*;
#(
    parameter int MAX_I      = 128,
    parameter int MAX_J      = 128,
    parameter int COORD_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ADDR_W-1:0]            paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COORD_BITS-1:0] node_x,
    input  wire logic signed [COORD_BITS-1:0] node_y,
    input  wire logic signed [COORD_BITS-1:0] node_z,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [COORD_BITS-1:0]      center_x,
    output logic signed [COORD_BITS-1:0]      center_y,
    output logic signed [COORD_BITS-1:0]      center_z,
    output logic [7:0]                        ext_i,
    output logic [7:0]                        ext_j,
    output logic [15:0]                       ext_k,
    output logic                              run_last
);
    localparam int SW     = COORD_BITS + 2;
    localparam int DW     = 24 * SW;
    localparam int QW     = $bits(ctrl_t) + DW;
    localparam int CAP_I  = (MAX_I > 255) ? 255 : MAX_I;
    localparam int CAP_J  = (MAX_J > 255) ? 255 : MAX_J;

    logic [7:0]  nodes_i_reg;
    logic [7:0]  nodes_j_reg;
    logic [15:0] nodes_k_reg;
    logic [7:0]  ni, nj;
    logic [15:0] nk;
    logic        wr_req;
    logic        restart;

    logic        f_valid, f_ready;
    ctrl_t       f_ctrl;
    logic [2:0][1:0][3:0][SW-1:0] f_sums;
    logic        b_valid, b_pop;
    logic [QW-1:0] b_word;
    ctrl_t       b_ctrl;
    logic [2:0][1:0][3:0][SW-1:0] b_sums;

    assign pready  = 1'b1;
    assign wr_req  = psel && penable && pwrite && pready;
    // Hold position unless a known register is written.
    assign restart = wr_req && (paddr[3:2] == REG_NODES_I || paddr[3:2] == REG_NODES_J
                                || paddr[3:2] == REG_NODES_K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_i_reg <= 8'd1;
            nodes_j_reg <= 8'd1;
            nodes_k_reg <= 16'd1;
        end
        else if (wr_req)
        begin
            unique case (paddr[3:2])
                REG_NODES_I: nodes_i_reg <= pwdata[7:0];
                REG_NODES_J: nodes_j_reg <= pwdata[7:0];
                REG_NODES_K: nodes_k_reg <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_NODES_I: prdata = {24'd0, nodes_i_reg};
            REG_NODES_J: prdata = {24'd0, nodes_j_reg};
            REG_NODES_K: prdata = {16'd0, nodes_k_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Effective sizes: zero acts as one, clamp to the history depth and to 255.
    assign ni = (nodes_i_reg == 8'd0) ? 8'd1 :
                (nodes_i_reg > 8'(CAP_I)) ? 8'(CAP_I) : nodes_i_reg;
    assign nj = (nodes_j_reg == 8'd0) ? 8'd1 :
                (nodes_j_reg > 8'(CAP_J)) ? 8'(CAP_J) : nodes_j_reg;
    assign nk = (nodes_k_reg == 16'd0) ? 16'd1 : nodes_k_reg;

    ecga_front #(.MAX_I(MAX_I), .MAX_J(MAX_J), .COORD_BITS(COORD_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .ni      (ni),
        .nj      (nj),
        .nk      (nk),
        .push    (push),
        .full    (full),
        .node_x  (node_x),
        .node_y  (node_y),
        .node_z  (node_z),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_ctrl  (f_ctrl),
        .q_sums  (f_sums)
    );

    ecga_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctrl, f_sums}),
        .out_valid (b_valid),
        .out_pop   (b_pop),
        .out_data  (b_word)
    );

    assign b_ctrl = b_word[QW-1:DW];
    assign b_sums = b_word[DW-1:0];

    ecga_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (b_valid),
        .q_pop    (b_pop),
        .q_ctrl   (b_ctrl),
        .q_sums   (b_sums),
        .empty    (empty),
        .pop      (pop),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .ext_i    (ext_i),
        .ext_j    (ext_j),
        .ext_k    (ext_k),
        .run_last (run_last)
    );
endmodule
`default_nettype wire

// ===== rtl/ecga_checker.sv =====
// Port-level checks of the extended center grid averaging block, bound to
// the top level. Depends on ecga_pkg.
`default_nettype none
module ecga_checker
    import ecga_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  pready,
    input wire logic                  empty,
    input wire logic                  pop,
    input wire logic [COORD_BITS-1:0] center_x,
    input wire logic [15:0]           ext_k,
    input wire logic                  run_last
);
    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(center_x))
        else $error("result changed while stalled");

    // Results of one node follow without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !run_last |=> !empty)
        else $error("gap inside a node's results");

    // Inside one node's run the k index steps by at most one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !run_last |=>
            (ext_k == $past(ext_k)) || (ext_k == $past(ext_k) + 16'd1))
        else $error("k index jumped inside a run");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");
endmodule

bind extended_center_grid_average ecga_checker #(.COORD_BITS(COORD_BITS)) u_ecga_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .empty    (empty),
    .pop      (pop),
    .center_x (center_x),
    .ext_k    (ext_k),
    .run_last (run_last)
);
`default_nettype wire
